// File: hw/rtl/tds_pkg.sv
`default_nettype none
package tds_pkg;

    localparam int NUM_TIMERS_DEFAULT = 64;
    localparam int FIRE_LIMIT_RESET   = 10;
    localparam int FIRE_LIMIT_MAX     = 16;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_STOP   = 2'd1,
        OP_UPDATE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  timer_id;
        logic [31:0] timeout;
        logic [31:0] repeat_period;
        logic [63:0] now;
    } cmd_t;

    typedef struct packed {
        logic [5:0] fired_id;
        logic       last;
    } result_t;

    function automatic logic [63:0] sat_add(input logic [63:0] base, input logic [31:0] delta);
        logic [64:0] sum;
        sum = {1'b0, base} + {33'd0, delta};
        return sum[64] ? '1 : sum[63:0];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tds_front.sv
`default_nettype none
module tds_front
    import tds_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      q_valid,
    output cmd_t      q_cmd,
    input  wire logic q_pop
);

    cmd_t       slot_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       keep;
    logic       push;
    logic       pop;

    // commands that change nothing are dropped here
    always_comb
    begin
        unique case (opcode_t'(cmd.opcode))
            OP_START, OP_STOP: keep = ({26'd0, cmd.timer_id} < 32'(NUM_TIMERS));
            OP_UPDATE:         keep = 1'b1;
            default:           keep = 1'b0;
        endcase
    end

    assign busy    = (fill_reg == 2'(QUEUE_DEPTH));
    assign push    = start && !busy && keep;
    assign pop     = q_pop && (fill_reg != 2'd0);
    assign q_valid = (fill_reg != 2'd0);
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd;
    end

endmodule
`default_nettype wire

// File: hw/rtl/tds_back.sv
`default_nettype none
module tds_back
    import tds_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire cmd_t       q_cmd,
    output logic            q_pop,
    input  wire logic [4:0] fire_limit,
    output logic            result_valid,
    output result_t         result
);

    localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [TW-1:0] LAST_IDX = TW'(NUM_TIMERS - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FIRE  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [95:0]           mem [NUM_TIMERS];
    logic [95:0]           rd_data_reg;
    logic [NUM_TIMERS-1:0] active_reg;

    logic [63:0]   now_reg;
    logic [4:0]    lim_reg;
    logic [4:0]    cnt_reg;
    logic [TW-1:0] addr_reg;
    logic          issue_reg;
    logic          rv_reg;
    logic          ract_reg;
    logic [TW-1:0] ridx_reg;
    logic          found_reg;
    logic [TW-1:0] best_idx_reg;
    logic [63:0]   best_dl_reg;
    logic [31:0]   best_per_reg;
    logic          pend_reg;
    logic [TW-1:0] pend_idx_reg;
    logic          out_vld_reg;
    result_t       out_reg;

    logic          mem_we;
    logic [TW-1:0] mem_wa;
    logic [95:0]   mem_wd;
    logic [63:0]   add_base;
    logic [31:0]   add_delta;
    logic          fire_now;
    logic          scan_end;
    logic [TW-1:0] cmd_idx;
    logic [4:0]    lim_clamped;

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign cmd_idx  = TW'(q_cmd.timer_id);
    assign fire_now = found_reg && (best_dl_reg <= now_reg);
    assign scan_end = rv_reg && (ridx_reg == LAST_IDX);

    always_comb
    begin
        priority if (fire_limit == 5'd0)
            lim_clamped = 5'd1;
        else if (fire_limit > 5'(FIRE_LIMIT_MAX))
            lim_clamped = 5'(FIRE_LIMIT_MAX);
        else
            lim_clamped = fire_limit;
    end

    // one saturating adder shared by arming and re-arming
    always_comb
    begin
        mem_we    = 1'b0;
        mem_wa    = cmd_idx;
        add_base  = q_cmd.now;
        add_delta = q_cmd.timeout;
        mem_wd    = {q_cmd.repeat_period, 64'd0};
        if (state_reg == ST_FIRE)
        begin
            mem_wa    = best_idx_reg;
            add_base  = now_reg;
            add_delta = best_per_reg;
            mem_wd    = {best_per_reg, 64'd0};
            mem_we    = fire_now && (best_per_reg != 32'd0);
        end
        else if (q_pop && (opcode_t'(q_cmd.opcode) == OP_START))
        begin
            mem_we = 1'b1;
        end
        mem_wd[63:0] = sat_add(add_base, add_delta);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[addr_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_pop && (opcode_t'(q_cmd.opcode) == OP_UPDATE))
                    state_next = ST_SCAN;
            ST_SCAN:
                if (scan_end)
                    state_next = ST_FIRE;
            ST_FIRE:
                if (!fire_now || (cnt_reg + 5'd1 == lim_reg))
                    state_next = ST_FLUSH;
                else
                    state_next = ST_SCAN;
            ST_FLUSH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= '0;
            issue_reg   <= 1'b0;
            rv_reg      <= 1'b0;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
            cnt_reg     <= 5'd0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= 1'b0;
            rv_reg      <= issue_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        unique case (opcode_t'(q_cmd.opcode))
                            OP_START:  active_reg[cmd_idx] <= 1'b1;
                            OP_STOP:   active_reg[cmd_idx] <= 1'b0;
                            OP_UPDATE:
                            begin
                                cnt_reg   <= 5'd0;
                                pend_reg  <= 1'b0;
                                issue_reg <= 1'b1;
                                found_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (issue_reg && (addr_reg == LAST_IDX))
                        issue_reg <= 1'b0;
                    if (rv_reg && ract_reg &&
                        (!found_reg || (rd_data_reg[63:0] < best_dl_reg)))
                        found_reg <= 1'b1;
                end
                ST_FIRE:
                begin
                    if (fire_now)
                    begin
                        if (best_per_reg == 32'd0)
                            active_reg[best_idx_reg] <= 1'b0;
                        out_vld_reg <= pend_reg;
                        pend_reg    <= 1'b1;
                        cnt_reg     <= cnt_reg + 5'd1;
                        if (cnt_reg + 5'd1 != lim_reg)
                        begin
                            issue_reg <= 1'b1;
                            found_reg <= 1'b0;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    out_vld_reg <= pend_reg;
                    pend_reg    <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && (opcode_t'(q_cmd.opcode) == OP_UPDATE))
        begin
            now_reg <= q_cmd.now;
            lim_reg <= lim_clamped;
        end
        if (state_reg == ST_IDLE || (state_reg == ST_FIRE))
            addr_reg <= '0;
        else if (issue_reg && (addr_reg != LAST_IDX))
            addr_reg <= addr_reg + TW'(1);
        ract_reg <= active_reg[addr_reg];
        ridx_reg <= addr_reg;
        if (state_reg == ST_SCAN && rv_reg && ract_reg &&
            (!found_reg || (rd_data_reg[63:0] < best_dl_reg)))
        begin
            best_idx_reg <= ridx_reg;
            best_dl_reg  <= rd_data_reg[63:0];
            best_per_reg <= rd_data_reg[95:64];
        end
        if (state_reg == ST_FIRE)
        begin
            out_reg.fired_id <= 6'(pend_idx_reg);
            out_reg.last     <= 1'b0;
            if (fire_now)
                pend_idx_reg <= best_idx_reg;
        end
        else if (state_reg == ST_FLUSH)
        begin
            out_reg.fired_id <= 6'(pend_idx_reg);
            out_reg.last     <= 1'b1;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("scheduler state not one-hot");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ($past(state_reg) == ST_FIRE || $past(state_reg) == ST_FLUSH))
        else $error("result issued outside fire or flush");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_SCAN) |-> (cnt_reg <= lim_reg))
        else $error("fire count beyond limit");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/timer_deadline_scheduler_core.sv
`default_nettype none
// Deadline-ordered timer table.
// Command channel: a transaction is taken when start is high and busy is low.
// cmd.opcode selects start (arm timer_id at now + timeout, repeat_period
// stored), stop (disarm timer_id) or update (fire expired timers).
// A two-entry queue sits between the command front and the executing back,
// so busy only rises when two commands are waiting.
// Start and stop take effect as they leave the queue.
// An update scans the whole table once per fired timer through the single
// read port of the timer memory, then fires the earliest expired timer,
// with one more scan when the update ends on an unexpired timer.
// Results come on result_valid for one cycle each, in firing order, with
// result.last set on the final one; the receiver cannot stall them.
// cfg_we writes the per-update fire limit (reset 10, clamped to 1..16);
// write it only while the block is idle.
// Reset disarms every timer; deadlines and periods need no clearing.
module timer_deadline_scheduler_core
    import tds_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire cmd_t       cmd,
    input  wire logic       cfg_we,
    input  wire logic [4:0] cfg_wdata,
    output logic            result_valid,
    output result_t         result
);

    logic [4:0] limit_reg;
    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 5'(FIRE_LIMIT_RESET);
        else if (cfg_we)
            limit_reg <= cfg_wdata;
    end

    tds_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    tds_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .fire_limit   (limit_reg),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
module testbench;
    import tds_pkg::*;

    localparam int NT          = 64;
    localparam int IDLE_LIMIT  = 20000;
    localparam int DRAIN_WAIT  = 2000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_t       cmd;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       result_valid;
    result_t    result;

    timer_deadline_scheduler_core #(.NUM_TIMERS(NT)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // scheduler state mirrored in the bench
    logic        tmr_armed [NT];
    logic [63:0] tmr_due   [NT];
    logic [31:0] tmr_rep   [NT];
    logic [4:0]  fire_cap;

    cmd_t    pending_cmds [$];
    result_t fires_due    [$];
    int      errors;
    int      n_taken;
    int      n_fired;
    int      quiet_cycles;
    int      gap_left;

    function automatic logic [63:0] deadline_add(logic [63:0] base, logic [31:0] delta);
        logic [64:0] s;
        s = {1'b0, base} + {33'd0, delta};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    // apply one transaction to the mirror and queue the timers it fires
    task automatic predict_fires(cmd_t c);
        int lim;
        int cnt;
        int best;
        result_t r;
        lim = (fire_cap == 0) ? 1 : (fire_cap > FIRE_LIMIT_MAX ? FIRE_LIMIT_MAX : fire_cap);
        cnt = 0;
        case (c.opcode)
            OP_START:
            begin
                tmr_armed[c.timer_id] = 1'b1;
                tmr_due[c.timer_id]   = deadline_add(c.now, c.timeout);
                tmr_rep[c.timer_id]   = c.repeat_period;
            end
            OP_STOP:
                tmr_armed[c.timer_id] = 1'b0;
            OP_UPDATE:
            begin
                while (cnt < lim)
                begin
                    best = -1;
                    for (int i = 0; i < NT; i++)
                        if (tmr_armed[i] && (best < 0 || tmr_due[i] < tmr_due[best]))
                            best = i;
                    if (best < 0 || tmr_due[best] > c.now)
                        break;
                    if (tmr_rep[best] != 0)
                        tmr_due[best] = deadline_add(c.now, tmr_rep[best]);
                    else
                        tmr_armed[best] = 1'b0;
                    r.fired_id = best[5:0];
                    r.last     = 1'b0;
                    fires_due.push_back(r);
                    cnt++;
                end
                if (cnt > 0)
                    fires_due[fires_due.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_fires(cmd);
                n_taken = n_taken + 1;
            end
            if (start && busy)
                ;
            else if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() > 0)
            begin
                start    <= 1'b1;
                cmd      <= pending_cmds.pop_front();
                gap_left <= pick_gap();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            n_fired = n_fired + 1;
            if (fires_due.size() == 0)
            begin
                $error("unexpected fire: fired_id %0d last %0b", result.fired_id, result.last);
                errors = errors + 1;
            end
            else
            begin
                if (result.fired_id !== fires_due[0].fired_id)
                begin
                    $error("fired_id expected %0d actual %0d",
                           fires_due[0].fired_id, result.fired_id);
                    errors = errors + 1;
                end
                if (result.last !== fires_due[0].last)
                begin
                    $error("last expected %0b actual %0b", fires_due[0].last, result.last);
                    errors = errors + 1;
                end
                void'(fires_due.pop_front());
            end
        end
    end

    // watchdog: cycles with no transaction either way
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic cmd_t mk(opcode_t op, logic [5:0] id, logic [31:0] tmo,
                                logic [31:0] rep, logic [63:0] t);
        cmd_t c;
        c.opcode        = op;
        c.timer_id      = id;
        c.timeout       = tmo;
        c.repeat_period = rep;
        c.now           = t;
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || start || busy || fires_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_cap(logic [4:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        fire_cap = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one phase of random traffic around a moving clock value
    task automatic random_phase(int n, logic [63:0] base);
        logic [63:0] t;
        logic [63:0] wide;
        int p;
        cmd_t c;
        t = base;
        for (int k = 0; k < n; k++)
        begin
            t = t + 64'($urandom_range(0, 40));
            p = $urandom_range(0, 99);
            c = mk(OP_START, 6'($urandom_range(0, 63)), $urandom_range(0, 120),
                   ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 90), t);
            if (p < 5)
            begin
                wide            = {$urandom, $urandom} >> $urandom_range(0, 31);
                c.timeout       = wide[63:32] | wide[31:0];
                c.repeat_period = $urandom;
            end
            if (p >= 45 && p < 60)
                c.opcode = OP_STOP;
            else if (p >= 60 && p < 94)
                c.opcode = OP_UPDATE;
            else if (p >= 94)
                c.opcode = OP_NONE;
            if ($urandom_range(0, 9) == 0)
                c.now = {$urandom, $urandom};
            pending_cmds.push_back(c);
        end
    endtask

    initial
    begin
        errors = 0; n_taken = 0; n_fired = 0;
        for (int i = 0; i < NT; i++)
        begin
            tmr_armed[i] = 1'b0; tmr_due[i] = '0; tmr_rep[i] = '0;
        end
        fire_cap  = FIRE_LIMIT_RESET;
        rst_n     = 1'b0;
        start     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cmd       = '0;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;

        // directed: extremes, stop of idle timer, saturation, ties, unused opcode
        pending_cmds.push_back(mk(OP_UPDATE, 6'd0, 32'd0, 32'd0, 64'd100));
        pending_cmds.push_back(mk(OP_STOP, 6'd5, 32'd0, 32'd0, 64'd0));
        pending_cmds.push_back(mk(OP_START, 6'd63, '1, '1, {64{1'b1}}));
        pending_cmds.push_back(mk(OP_START, 6'd0, 32'd0, 32'd0, 64'd10));
        pending_cmds.push_back(mk(OP_START, 6'd7, 32'd5, 32'd3, 64'd5));
        pending_cmds.push_back(mk(OP_START, 6'd3, 32'd5, 32'd0, 64'd5));
        pending_cmds.push_back(mk(OP_START, 6'd3, 32'd20, 32'd0, 64'd6));
        pending_cmds.push_back(mk(OP_NONE, 6'd1, '1, '1, '1));
        pending_cmds.push_back(mk(OP_UPDATE, 6'd9, '1, '1, 64'd10));
        pending_cmds.push_back(mk(OP_UPDATE, 6'd0, 32'd0, 32'd0, 64'd30));
        pending_cmds.push_back(mk(OP_STOP, 6'd7, '1, '1, 64'd31));
        pending_cmds.push_back(mk(OP_START, 6'd42, 32'h8000_0000, 32'd0, 64'hFFFF_FFFF_0000_0000));
        pending_cmds.push_back(mk(OP_UPDATE, 6'd0, 32'd0, 32'd0, {64{1'b1}}));
        for (int i = 0; i < 12; i++)
            pending_cmds.push_back(mk(OP_START, 6'(i * 5), 32'd0, 32'd1, 64'd50));
        pending_cmds.push_back(mk(OP_UPDATE, 6'd0, 32'd0, 32'd0, 64'd50));
        wait_drained();

        write_cap(5'd1);
        random_phase(80, 64'd1000);
        wait_drained();
        write_cap(5'd0);
        random_phase(40, 64'd5000);
        wait_drained();
        write_cap(5'd31);
        random_phase(80, 64'd9000);
        wait_drained();
        write_cap(5'd16);
        random_phase(70, 64'hFFFF_FFFF_FFFF_0000);
        wait_drained();
        write_cap(5'd3);
        random_phase(60, 64'd20000);
        wait_drained();

        $display("run: %0d commands taken, %0d timer fires checked, fire limits 0..31",
                 n_taken, n_fired);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
